// ----- design/pli_pkg.sv -----
// shared types and constants for the piecewise linear interpolator
// used by pli_ctrl, pli_dp and the top level; depends on nothing

package pli_pkg;

    // item kinds carried on the slave-side tuser
    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_QUERY  = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    // field widths
    localparam int X_W      = 16;
    localparam int Y_W      = 16;
    localparam int RES_W    = 24;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_USER_W = 2;

    // quotient bits produced by the serial divider
    localparam int DIV_STEPS = 24;
    localparam int DIV_CNT_W = 5;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;        // latch the accepted beat
        logic load_query;  // the accepted beat is a query
        logic clear;       // empty the table
        logic write;       // append the latched point
        logic scan_adv;    // read the next table entry
        logic take_prev;   // keep the entry just read as segment start
        logic take_seg;    // latch the hit segment
        logic mul1;        // y0 * dx
        logic mul2;        // dy * dq
        logic sum;         // add the two products
        logic div_init;    // magnitude and divider load
        logic div_step;    // one quotient bit
        logic store_y;     // signed quotient into the result
        logic out_load;    // result into the output register
    } pli_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic few;         // fewer than two points held
        logic hit;         // current segment holds the query
        logic last;        // current entry is the last one held
        logic div_last;    // divider on its final step
        logic out_free;    // output register can take a result
    } pli_sts_t;

endpackage

// ----- design/pli_ctrl.sv -----
// controller state machine of the piecewise linear interpolator
// depends on pli_pkg; drives pli_dp through command and status structs

module pli_ctrl
    import pli_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic [1:0] s_tuser,
    output logic       s_tready,
    input  pli_sts_t   sts,
    output pli_cmd_t   cmd
);

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b0000_0000_0001,
        ST_WRITE = 12'b0000_0000_0010,
        ST_RD0   = 12'b0000_0000_0100,
        ST_RD1   = 12'b0000_0000_1000,
        ST_SCAN  = 12'b0000_0001_0000,
        ST_MUL1  = 12'b0000_0010_0000,
        ST_MUL2  = 12'b0000_0100_0000,
        ST_SUM   = 12'b0000_1000_0000,
        ST_ABS   = 12'b0001_0000_0000,
        ST_DIV   = 12'b0010_0000_0000,
        ST_DONE  = 12'b0100_0000_0000,
        ST_FIN   = 12'b1000_0000_0000
    } pli_state_t;

    pli_state_t state_reg;
    pli_state_t state_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load = 1'b1;
                    unique case (s_tuser)
                        MODE_APPEND:
                        begin
                            state_next = ST_WRITE;
                        end
                        MODE_QUERY:
                        begin
                            cmd.load_query = 1'b1;
                            state_next     = sts.few ? ST_FIN : ST_RD0;
                        end
                        MODE_CLEAR:
                        begin
                            cmd.clear = 1'b1;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_WRITE:
            begin
                cmd.write  = 1'b1;
                state_next = ST_FIN;
            end
            ST_RD0:
            begin
                cmd.scan_adv = 1'b1;
                state_next   = ST_RD1;
            end
            ST_RD1:
            begin
                cmd.scan_adv  = 1'b1;
                cmd.take_prev = 1'b1;
                state_next    = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (sts.hit)
                begin
                    cmd.take_seg = 1'b1;
                    state_next   = ST_MUL1;
                end
                else if (sts.last)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cmd.scan_adv  = 1'b1;
                    cmd.take_prev = 1'b1;
                end
            end
            ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_ABS;
            end
            ST_ABS:
            begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                cmd.store_y = 1'b1;
                state_next  = ST_FIN;
            end
            ST_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- design/pli_dp.sv -----
// datapath of the piecewise linear interpolator: breakpoint memory,
// segment scan, shared multiplier, serial divider and output register
// depends on pli_pkg; commanded by pli_ctrl

module pli_dp
    import pli_pkg::*;
#(
    parameter int MAX_POINTS = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  pli_cmd_t              cmd,
    output pli_sts_t              sts,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [OUT_USER_W-1:0] m_tuser
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int ENT_W = X_W + Y_W;

    // breakpoint memory, x in the upper half
    logic [ENT_W-1:0] mem [MAX_POINTS];
    logic [ENT_W-1:0] rd_data_reg;
    logic [IDX_W-1:0] rd_addr;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] rd_idx_reg;

    // latched beat
    logic [X_W-1:0]   px_reg;
    logic [Y_W-1:0]   py_reg;
    logic [X_W-1:0]   q_reg;

    // segment start kept during the scan
    logic [ENT_W-1:0] prev_reg;

    // segment operands
    logic [X_W-1:0]         dx_reg;
    logic [X_W-1:0]         dq_reg;
    logic signed [Y_W:0]    y0_reg;
    logic signed [Y_W:0]    dy_reg;

    // shared multiplier and sum
    logic signed [Y_W:0]     mul_a;
    logic signed [Y_W:0]     mul_b;
    logic signed [2*Y_W+1:0] mul_p;
    logic signed [2*Y_W+1:0] prod1_reg;
    logic signed [2*Y_W+1:0] prod2_reg;
    logic signed [2*Y_W+2:0] sum_reg;
    logic [2*Y_W+2:0]        mag;

    // serial divider
    logic [X_W-1:0]       rem_reg;
    logic [RES_W-1:0]     dvd_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic                 neg_reg;
    logic [X_W:0]         trial;
    logic                 trial_ge;
    logic [X_W:0]         trial_sub;

    // result and output register
    logic [RES_W-1:0] res_y_reg;
    logic             res_found_reg;
    logic             res_full_reg;
    logic             out_valid_reg;
    logic [X_W-1:0]   out_x_reg;
    logic [RES_W-1:0] out_y_reg;
    logic             out_found_reg;
    logic             out_full_reg;

    logic full;
    logic [X_W-1:0] cur_x;
    logic [X_W-1:0] prev_x;

    assign full   = (count_reg >= CNT_W'(MAX_POINTS));
    assign cur_x  = rd_data_reg[ENT_W-1:Y_W];
    assign prev_x = prev_reg[ENT_W-1:Y_W];

    // read address stays inside the array
    assign rd_addr = (rd_idx_reg < CNT_W'(MAX_POINTS)) ? rd_idx_reg[IDX_W-1:0] : '0;

    // status
    assign sts.few      = (count_reg < CNT_W'(2));
    assign sts.hit      = (q_reg >= prev_x) && (q_reg <= cur_x);
    assign sts.last     = (rd_idx_reg == count_reg);
    assign sts.div_last = (div_cnt_reg == DIV_CNT_W'(1));
    assign sts.out_free = !out_valid_reg || m_tready;

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.write && !full)
        begin
            mem[count_reg[IDX_W-1:0]] <= {px_reg, py_reg};
        end
        rd_data_reg <= mem[rd_addr];
    end

    // fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.clear)
        begin
            count_reg <= '0;
        end
        else if (cmd.write && !full)
        begin
            count_reg <= count_reg + CNT_W'(1);
        end
    end

    // multiplier operand selection
    always_comb
    begin
        if (cmd.mul2)
        begin
            mul_a = dy_reg;
            mul_b = $signed({1'b0, dq_reg});
        end
        else
        begin
            mul_a = y0_reg;
            mul_b = $signed({1'b0, dx_reg});
        end
    end
    assign mul_p = mul_a * mul_b;

    // magnitude of the numerator
    assign mag = sum_reg[2*Y_W+2] ? 35'(-sum_reg) : 35'(sum_reg);

    // one restoring divide step
    assign trial     = {rem_reg, dvd_reg[RES_W-1]};
    assign trial_ge  = (trial >= {1'b0, dx_reg});
    assign trial_sub = trial - {1'b0, dx_reg};

    // scan, arithmetic and divider registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            px_reg     <= s_tdata[X_W-1:0];
            py_reg     <= s_tdata[X_W+Y_W-1:X_W];
            q_reg      <= cmd.load_query ? s_tdata[IN_DATA_W-1:X_W+Y_W] : '0;
            rd_idx_reg <= '0;
        end
        else if (cmd.scan_adv)
        begin
            rd_idx_reg <= rd_idx_reg + CNT_W'(1);
        end

        if (cmd.take_prev)
        begin
            prev_reg <= rd_data_reg;
        end

        // segment operands, zero width divides by one
        if (cmd.take_seg)
        begin
            dx_reg <= (cur_x == prev_x) ? X_W'(1) : cur_x - prev_x;
            dq_reg <= q_reg - prev_x;
            y0_reg <= $signed({prev_reg[Y_W-1], prev_reg[Y_W-1:0]});
            dy_reg <= $signed({rd_data_reg[Y_W-1], rd_data_reg[Y_W-1:0]})
                    - $signed({prev_reg[Y_W-1], prev_reg[Y_W-1:0]});
        end

        if (cmd.mul1)
        begin
            prod1_reg <= mul_p;
        end
        if (cmd.mul2)
        begin
            prod2_reg <= mul_p;
        end
        if (cmd.sum)
        begin
            sum_reg <= 35'(prod1_reg) + 35'(prod2_reg);
        end

        // quotient below 2^24 so the top bits go straight into the remainder
        if (cmd.div_init)
        begin
            neg_reg     <= sum_reg[2*Y_W+2];
            rem_reg     <= mag[31:16];
            dvd_reg     <= {mag[15:0], 8'b0};
            div_cnt_reg <= DIV_CNT_W'(DIV_STEPS);
        end
        else if (cmd.div_step)
        begin
            rem_reg     <= trial_ge ? trial_sub[X_W-1:0] : trial[X_W-1:0];
            dvd_reg     <= {dvd_reg[RES_W-2:0], trial_ge};
            div_cnt_reg <= div_cnt_reg - DIV_CNT_W'(1);
        end
    end

    // result of the item in work
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            res_y_reg     <= '0;
            res_found_reg <= 1'b0;
            res_full_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.write)
            begin
                res_full_reg <= full;
            end
            if (cmd.store_y)
            begin
                res_y_reg     <= neg_reg ? -dvd_reg : dvd_reg;
                res_found_reg <= 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_x_reg     <= q_reg;
            out_y_reg     <= res_y_reg;
            out_found_reg <= res_found_reg;
            out_full_reg  <= res_full_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_y_reg, out_x_reg};
    assign m_tuser  = {out_full_reg, out_found_reg};

endmodule

// ----- design/piecewise_linear_interpolator.sv -----
// channel   dir  tdata                                  tuser
// s_*       in   [15:0] point_x [31:16] point_y          [1:0] mode
//                [47:32] query_x
// m_*       out  [15:0] echo_x [39:16] interp_y         [0] in_range [1] table_full
//
// one item in work at a time; s_tready is high only while idle
// append: result via ST_WRITE and ST_FIN; clear: no result, input open again the next cycle
// query over N points: time to the result is set by the one-entry-a-cycle
// scan through the single read port of the breakpoint memory and the 24-step divider
// a held result in the output register does not stop the next beat from being taken
// reset empties the table and drops any held result; memory contents are not cleared
//
// top level of the piecewise linear interpolator; depends on pli_pkg, pli_ctrl, pli_dp

module piecewise_linear_interpolator
    import pli_pkg::*;
#(
    parameter int MAX_POINTS = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // point_x, point_y, query_x
    input  logic [1:0]            s_tuser,   // mode
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // echo_x, interp_y
    output logic [OUT_USER_W-1:0] m_tuser    // in_range, table_full
);

    pli_cmd_t cmd;
    pli_sts_t sts;

    // controller
    pli_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath
    pli_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ----- design/pli_checker.sv -----
// port-level checks for the piecewise linear interpolator
// depends on pli_pkg; bound to piecewise_linear_interpolator below

module pli_checker
    import pli_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [1:0]            s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic [OUT_USER_W-1:0] m_tuser
);

    // no result beat held through reset
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("result beat offered during reset");

    // stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result beat changed");

    // a dropped append never claims a found segment
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("in_range and table_full both set");

    // no interpolated value without a segment
    a_zero_y: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[39:16] == 24'd0)
        else $error("interp_y non-zero outside the table span");

    // an append or query beat keeps the input closed on the next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == MODE_APPEND || s_tuser == MODE_QUERY)
        |=> !s_tready)
        else $error("beat taken while an item is in work");

endmodule

bind piecewise_linear_interpolator pli_checker u_pli_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- test/tb_top.sv -----
// self-checking testbench for piecewise_linear_interpolator: random and directed table
// loads, clears and queries against an in-bench interpolation predictor
// depends on pli_pkg and the piecewise_linear_interpolator top level

module tb_top;
    import pli_pkg::*;

    localparam int MAX_POINTS = 64;
    localparam int ITEM_GOAL = 1850;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]         mode;
        logic [15:0]        px;
        logic signed [15:0] py;
        logic [15:0]        qx;
    } beat_t;

    typedef struct packed {
        logic [15:0]        echo_x;
        logic signed [23:0] interp_y;
        logic               in_range;
        logic               table_full;
    } lerp_res_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [1:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;

    // stimulus and prediction state
    beat_t              stim_beats[$];
    beat_t              beat_on_bus;
    lerp_res_t          expected_lerp[$];
    lerp_res_t          want;
    logic [15:0]        knot_x[MAX_POINTS];
    logic signed [15:0] knot_y[MAX_POINTS];
    int                 knot_count = 0;
    logic [31:0]        accepted_cnt = '0;
    logic [1:0]         idle_phase;
    int                 hold_left = 0;
    logic               hold_done = 1'b0;
    int                 fail_cnt = 0;
    int                 planned = 0;

    // 0 no idling, 1 sender idle, 2 receiver stalls, 3 both lightly
    assign idle_phase = accepted_cnt[8:7];

    piecewise_linear_interpolator #(
        .MAX_POINTS(MAX_POINTS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    // table update and expected result for one accepted beat
    task automatic interpolate_beat(input beat_t b);
        lerp_res_t r;
        longint    x0;
        longint    x1;
        longint    y0;
        longint    y1;
        longint    q;
        longint    dx;
        longint    val;
        r = '0;
        case (b.mode)
            MODE_APPEND:
            begin
                if (knot_count < MAX_POINTS)
                begin
                    knot_x[knot_count] = b.px;
                    knot_y[knot_count] = b.py;
                    knot_count++;
                end
                else
                    r.table_full = 1'b1;
                expected_lerp.push_back(r);
            end
            MODE_QUERY:
            begin
                r.echo_x = b.qx;
                q = b.qx;
                // first segment holding the query wins
                for (int j = 1; j < knot_count && !r.in_range; j++)
                begin
                    x0 = knot_x[j-1];
                    x1 = knot_x[j];
                    y0 = knot_y[j-1];
                    y1 = knot_y[j];
                    if (q >= x0 && q <= x1)
                    begin
                        if (x1 == x0)
                            val = y0 * 256;
                        else
                        begin
                            dx = x1 - x0;
                            val = (y0 * 256 * dx + (y1 - y0) * (q - x0) * 256) / dx;
                        end
                        r.interp_y = val[23:0];
                        r.in_range = 1'b1;
                    end
                end
                expected_lerp.push_back(r);
            end
            MODE_CLEAR:
                knot_count = 0;
            default:
                ;
        endcase
    endtask

    task automatic push_beat(input logic [1:0] mode, input int px, input int py, input int qx);
        beat_t b;
        b.mode = mode;
        b.px = px[15:0];
        b.py = py[15:0];
        b.qx = qx[15:0];
        stim_beats.push_back(b);
        if (mode == MODE_APPEND || mode == MODE_QUERY)
            planned++;
    endtask

    // random tables, some unordered or overfull; queries aimed mostly inside the span
    task automatic build_random_stim();
        int xs[$];
        int roll;
        int n;
        int x;
        int step_max;
        int nq;
        int lim;
        int j;
        int q;
        logic sorted;
        while (planned < ITEM_GOAL)
        begin
            if ($urandom_range(9) != 0)
            begin
                push_beat(MODE_CLEAR, $urandom_range(65535), $urandom_range(65535),
                          $urandom_range(65535));
                xs.delete();
            end
            roll = $urandom_range(99);
            n = roll < 60 ? $urandom_range(8) : roll < 85 ? $urandom_range(20, 9) :
                roll < 95 ? $urandom_range(64, 21) : $urandom_range(67, 65);
            sorted = $urandom_range(9) != 0;
            x = $urandom_range(1) ? $urandom_range(255) : $urandom_range(65535);
            step_max = (65535 - x) / (n > 0 ? n : 1);
            for (int i = 0; i < n; i++)
            begin
                if (!sorted)
                    x = $urandom_range(65535);
                else if (i > 0 && $urandom_range(7) != 0)
                    x = x + $urandom_range(step_max);
                push_beat(MODE_APPEND, x, $urandom_range(65535), $urandom_range(65535));
                xs.push_back(x);
            end
            nq = $urandom_range(12, 2);
            lim = xs.size() > MAX_POINTS ? MAX_POINTS : xs.size();
            for (int k = 0; k < nq; k++)
            begin
                if ($urandom_range(19) == 0)
                    push_beat(MODE_UNUSED, $urandom_range(65535), $urandom_range(65535),
                              $urandom_range(65535));
                roll = $urandom_range(99);
                if (lim >= 2 && roll < 70)
                begin
                    j = $urandom_range(lim - 1, 1);
                    q = $urandom_range(xs[j-1], xs[j]);
                end
                else if (lim >= 1 && roll < 82)
                    q = xs[$urandom_range(lim - 1)];
                else
                    q = $urandom_range(65535);
                push_beat(MODE_QUERY, $urandom_range(65535), $urandom_range(65535), q);
            end
        end
    endtask

    // driver: offers pending beats, predicts each accepted one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                interpolate_beat(beat_on_bus);
                accepted_cnt <= accepted_cnt + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (stim_beats.size() != 0 &&
                    $urandom_range(99) >= (idle_phase == 1 ? 68 : idle_phase == 3 ? 18 : 0))
                begin
                    beat_on_bus = stim_beats.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {beat_on_bus.qx, beat_on_bus.py, beat_on_bus.px};
                    s_tuser <= beat_on_bus.mode;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // long receiver hold-off once, so the block fills and stalls its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && accepted_cnt >= 400)
        begin
            hold_left <= 300;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // monitor: checks each result beat against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_lerp.size() == 0)
                begin
                    $error("result beat with nothing predicted: tdata %h tuser %h",
                           m_tdata, m_tuser);
                    fail_cnt++;
                end
                else
                begin
                    want = expected_lerp.pop_front();
                    if (m_tdata[15:0] !== want.echo_x)
                    begin
                        $error("echo_x expected %0d got %0d", want.echo_x, m_tdata[15:0]);
                        fail_cnt++;
                    end
                    if (m_tdata[39:16] !== want.interp_y)
                    begin
                        $error("interp_y expected %0d got %0d", want.interp_y,
                               $signed(m_tdata[39:16]));
                        fail_cnt++;
                    end
                    if (m_tuser[0] !== want.in_range)
                    begin
                        $error("in_range expected %0d got %0d", want.in_range, m_tuser[0]);
                        fail_cnt++;
                    end
                    if (m_tuser[1] !== want.table_full)
                    begin
                        $error("table_full expected %0d got %0d", want.table_full, m_tuser[1]);
                        fail_cnt++;
                    end
                end
            end
            m_tready <= hold_left == 0 &&
                        $urandom_range(99) >= (idle_phase == 2 ? 68 : idle_phase == 3 ? 18 : 0);
        end
    end

    // stimulus, reset and end of run
    initial
    begin
        // empty and single-point tables
        push_beat(MODE_QUERY, 0, 0, 0);
        push_beat(MODE_APPEND, 0, -32768, 0);
        push_beat(MODE_QUERY, 0, 0, 0);
        // full-range segment between the field extremes
        push_beat(MODE_APPEND, 65535, 32767, 0);
        push_beat(MODE_QUERY, 0, 0, 0);
        push_beat(MODE_QUERY, 0, 0, 65535);
        push_beat(MODE_QUERY, 0, 0, 32768);
        push_beat(MODE_QUERY, 0, 0, 1);
        // zero-width first segment and queries just outside the span
        push_beat(MODE_CLEAR, 0, 0, 0);
        push_beat(MODE_APPEND, 100, 5, 0);
        push_beat(MODE_APPEND, 100, -7, 0);
        push_beat(MODE_APPEND, 200, 9, 0);
        push_beat(MODE_QUERY, 0, 0, 100);
        push_beat(MODE_QUERY, 0, 0, 150);
        push_beat(MODE_QUERY, 0, 0, 99);
        push_beat(MODE_QUERY, 0, 0, 201);
        // unused mode must leave the table alone
        push_beat(MODE_UNUSED, 65535, -1, 65535);
        // unordered table
        push_beat(MODE_CLEAR, 0, 0, 0);
        push_beat(MODE_APPEND, 500, 1, 0);
        push_beat(MODE_APPEND, 300, 2, 0);
        push_beat(MODE_APPEND, 400, -3, 0);
        push_beat(MODE_QUERY, 0, 0, 450);
        push_beat(MODE_QUERY, 0, 0, 350);
        push_beat(MODE_QUERY, 0, 0, 500);
        build_random_stim();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (stim_beats.size() != 0 || s_tvalid)
            @(posedge clk);
        while (expected_lerp.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
        if (expected_lerp.size() != 0)
        begin
            $error("%0d predicted results never arrived", expected_lerp.size());
            fail_cnt++;
        end
        if (fail_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // run limit
    initial
    begin
        #40_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
